// ===== design/sgmii_basex_aneg_resolver_macros.svh =====
// Assertion macros used by the resolver top level.
`ifndef SGMII_BASEX_ANEG_RESOLVER_MACROS_SVH
`define SGMII_BASEX_ANEG_RESOLVER_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset.
`define SBAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define SBAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sbar_pkg.sv =====
// Types, constants and codes shared by the auto-negotiation resolver.
package sbar_pkg;

    // capability bits: 4=1000F 3=1000H 2=100F 1=100H 0=pause
    localparam int CAP_W = 5;
    localparam int CAP_PAUSE = 0;
    localparam int CAP_100H  = 1;
    localparam int CAP_100F  = 2;
    localparam int CAP_1000H = 3;
    localparam int CAP_1000F = 4;

    localparam logic [CAP_W-1:0] CAPS_SGMII = 5'b11110;
    localparam logic [CAP_W-1:0] CAPS_BASEX = 5'b10001;
    localparam logic [CAP_W-1:0] CAPS_RESET = 5'b11111;

    // partner word bits
    localparam logic [15:0] W_SGMII_ACKMASK  = 16'h8C00;
    localparam logic [15:0] W_SGMII_LINK     = 16'h8000;
    localparam logic [15:0] W_BASEX_FULLMASK = 16'h4020;
    localparam int WB_SGMII_LINK  = 15;
    localparam int WB_SGMII_FDX   = 12;
    localparam int WB_SGMII_1000  = 11;
    localparam int WB_SGMII_100   = 10;
    localparam int WB_BASEX_PAUSE = 7;
    localparam int WB_BASEX_LINK  = 5;
    localparam int WB_BASEX_FULL  = 5;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        RF_NONE     = 2'b00,
        RF_LINKFAIL = 2'b01,
        RF_OFFLINE  = 2'b10,
        RF_ANEG_ERR = 2'b11
    } rfault_t;

    typedef enum logic [1:0] {
        REG_SUPPORTED  = 2'd0,
        REG_ADVERTISED = 2'd1,
        REG_BASEX      = 2'd2,
        REG_AUTODETECT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        SPD_10M  = 2'd0,
        SPD_100M = 2'd1,
        SPD_1G   = 2'd2
    } speed_t;

    typedef enum logic [2:0] {
        OUTC_OK          = 3'd0,
        OUTC_LINK_DOWN   = 3'd1,
        OUTC_OFFLINE     = 3'd2,
        OUTC_LINK_FAIL   = 3'd3,
        OUTC_ANEG_ERR    = 3'd4,
        OUTC_BASEX_UNSUP = 3'd5,
        OUTC_SPEED_UNSUP = 3'd6
    } outcome_t;

    typedef struct packed {
        logic [CAP_W-1:0] supported;
        logic [CAP_W-1:0] advertised;
        logic             basex;
        logic             autodetect;
    } cfg_t;

    typedef struct packed {
        logic             mode_basex;
        logic [CAP_W-1:0] supported;
        logic [CAP_W-1:0] advertised;
        speed_t           last_speed;
        logic             last_fdx;
        logic             last_pause;
    } state_t;

    typedef struct packed {
        logic     link_up;
        speed_t   speed;
        logic     full_duplex;
        logic     pause_on;
        logic     mode_basex;
        logic     mode_switched;
        logic     speed_write;
        outcome_t outcome;
    } result_t;

endpackage

// ===== design/sbar_cfg.sv =====
// APB configuration registers; any register write pulses a state reload.
module sbar_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sbar_pkg::APB_AW-1:0] paddr,
    input  logic [sbar_pkg::APB_DW-1:0] pwdata,
    output logic [sbar_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output sbar_pkg::cfg_t             cfg,
    output sbar_pkg::cfg_t             cfg_new,
    output logic                       cfg_wr
);
    import sbar_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;

    assign pready  = 1'b1;
    assign idx     = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;
    // register values as they stand after this cycle's write
    assign cfg_new = cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (idx)
                REG_SUPPORTED:  cfg_next.supported  = pwdata[CAP_W-1:0];
                REG_ADVERTISED: cfg_next.advertised = pwdata[CAP_W-1:0];
                REG_BASEX:      cfg_next.basex      = pwdata[0];
                REG_AUTODETECT: cfg_next.autodetect = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.supported  <= CAPS_RESET;
            cfg_reg.advertised <= CAPS_RESET;
            cfg_reg.basex      <= 1'b0;
            cfg_reg.autodetect <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_SUPPORTED:  prdata = {{(APB_DW-CAP_W){1'b0}}, cfg_reg.supported};
            REG_ADVERTISED: prdata = {{(APB_DW-CAP_W){1'b0}}, cfg_reg.advertised};
            REG_BASEX:      prdata = {{(APB_DW-1){1'b0}}, cfg_reg.basex};
            REG_AUTODETECT: prdata = {{(APB_DW-1){1'b0}}, cfg_reg.autodetect};
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== design/sbar_resolve.sv =====
// Combinational resolution of one status poll against the held state.
module sbar_resolve (
    input  logic [15:0]      partner_word,
    input  logic             base_link_up,
    input  logic             autodetect,
    input  sbar_pkg::state_t st,
    output sbar_pkg::state_t st_next,
    output sbar_pkg::result_t res
);
    import sbar_pkg::*;

    logic             link;
    logic             mode;
    logic             switched;
    logic             do_full;
    logic [CAP_W-1:0] sup;
    logic [CAP_W-1:0] adv;
    logic [CAP_W-1:0] both;
    rfault_t          rf;

    assign rf = rfault_t'(partner_word[13:12]);

    always_comb begin
        link = base_link_up &&
               (st.mode_basex ? partner_word[WB_BASEX_LINK] : partner_word[WB_SGMII_LINK]);
        mode     = st.mode_basex;
        sup      = st.supported;
        adv      = st.advertised;
        switched = 1'b0;
        do_full  = 1'b1;
        both     = '0;

        res.link_up       = 1'b1;
        res.speed         = SPD_10M;
        res.full_duplex   = 1'b0;
        res.pause_on      = 1'b0;
        res.mode_switched = 1'b0;
        res.speed_write   = 1'b0;
        res.outcome       = OUTC_OK;

        if (!link) begin
            res.link_up     = 1'b0;
            res.speed       = st.last_speed;
            res.full_duplex = st.last_fdx;
            res.pause_on    = st.last_pause;
            res.outcome     = OUTC_LINK_DOWN;
        end else begin
            if (autodetect) begin
                if (mode && ((partner_word & W_SGMII_ACKMASK) > W_SGMII_LINK)) begin
                    mode     = 1'b0;
                    sup      = CAPS_SGMII;
                    adv      = adv & CAPS_SGMII;
                    switched = 1'b1;
                end else if (!mode &&
                             ((partner_word & W_BASEX_FULLMASK) == W_BASEX_FULLMASK)) begin
                    mode     = 1'b1;
                    sup      = CAPS_BASEX;
                    adv      = adv & CAPS_BASEX;
                    switched = 1'b1;
                end
            end
            both = sup & adv;
            res.mode_switched = switched;

            if (mode) begin
                if (!both[CAP_1000F]) begin
                    res.outcome = OUTC_BASEX_UNSUP;
                end else begin
                    case (rf)
                        RF_OFFLINE: begin
                            res.outcome = OUTC_OFFLINE;
                            do_full     = 1'b0;
                        end
                        RF_LINKFAIL: begin
                            res.outcome = OUTC_LINK_FAIL;
                            do_full     = 1'b0;
                        end
                        RF_ANEG_ERR: begin
                            // negotiation error: flip advertised pause, when pause is supported, to retry
                            res.outcome    = OUTC_ANEG_ERR;
                            adv[CAP_PAUSE] = adv[CAP_PAUSE] ^ sup[CAP_PAUSE];
                        end
                        default: begin
                            adv[CAP_PAUSE] = sup[CAP_PAUSE] & partner_word[WB_BASEX_PAUSE];
                            res.pause_on   = adv[CAP_PAUSE];
                        end
                    endcase
                    if (do_full && partner_word[WB_BASEX_FULL]) begin
                        adv[CAP_1000F]  = 1'b1;
                        res.speed       = SPD_1G;
                        res.full_duplex = 1'b1;
                        res.speed_write = 1'b1;
                    end
                end
            end else begin
                if (partner_word[WB_SGMII_1000]) begin
                    if (both[CAP_1000F] || both[CAP_1000H]) begin
                        res.speed       = SPD_1G;
                        res.speed_write = 1'b1;
                    end else begin
                        res.outcome = OUTC_SPEED_UNSUP;
                    end
                end else if (partner_word[WB_SGMII_100]) begin
                    if (both[CAP_100F] || both[CAP_100H]) begin
                        res.speed       = SPD_100M;
                        res.speed_write = 1'b1;
                    end else begin
                        res.outcome = OUTC_SPEED_UNSUP;
                    end
                end else begin
                    res.speed_write = 1'b1;
                end
                res.full_duplex = partner_word[WB_SGMII_FDX] &&
                                  (both[CAP_100F] || both[CAP_1000F]);
            end
        end
        res.mode_basex = mode;

        if (link) begin
            st_next.mode_basex = mode;
            st_next.supported  = sup;
            st_next.advertised = adv;
            st_next.last_speed = res.speed;
            st_next.last_fdx   = res.full_duplex;
            st_next.last_pause = res.pause_on;
        end else begin
            st_next = st;
        end
    end

endmodule

// ===== design/sgmii_basex_aneg_resolver.sv =====
// Top level: input register, resolve logic with held state, result register, APB port.
// One status poll is accepted per cycle unless the output stalls; each gives one result
// item via the input, then the result register; the held mode and capability state is
// read and rewritten by the resolve logic in the same cycle an item moves to the result
// register, so consecutive polls chain without gaps. A configuration write reloads the
// held state from the configuration registers and is meant for an idle block.
`include "sgmii_basex_aneg_resolver_macros.svh"

module sgmii_basex_aneg_resolver (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,  // [15:0] partner_word, [16] base_link_up
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] link_up, [2:1] speed_code, [3] full_duplex, [4] pause_on, [5] mode_basex,
    // [6] mode_switched, [7] speed_reg_write, [10:8] outcome
    output logic [15:0]                 m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbar_pkg::APB_AW-1:0] paddr,
    input  logic [sbar_pkg::APB_DW-1:0] pwdata,
    output logic [sbar_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import sbar_pkg::*;

    cfg_t    cfg;
    cfg_t    cfg_new;
    logic    cfg_wr;
    logic    in_valid_reg;
    logic [15:0] word_reg;
    logic    base_reg;
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;
    state_t  state_reg;
    state_t  state_next;
    logic    advance;

    sbar_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_new (cfg_new),
        .cfg_wr  (cfg_wr)
    );

    sbar_resolve u_resolve (
        .partner_word (word_reg),
        .base_link_up (base_reg),
        .autodetect   (cfg.autodetect),
        .st           (state_reg),
        .st_next      (state_next),
        .res          (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            word_reg <= s_tdata[15:0];
            base_reg <= s_tdata[16];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode_basex <= 1'b0;
            state_reg.supported  <= CAPS_RESET;
            state_reg.advertised <= CAPS_RESET;
            state_reg.last_speed <= SPD_10M;
            state_reg.last_fdx   <= 1'b0;
            state_reg.last_pause <= 1'b0;
        end else if (cfg_wr) begin
            state_reg.mode_basex <= cfg_new.basex;
            state_reg.supported  <= cfg_new.supported;
            state_reg.advertised <= cfg_new.advertised;
            state_reg.last_speed <= SPD_10M;
            state_reg.last_fdx   <= 1'b0;
            state_reg.last_pause <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, res_reg.outcome, res_reg.speed_write, res_reg.mode_switched,
                       res_reg.mode_basex, res_reg.pause_on, res_reg.full_duplex,
                       res_reg.speed, res_reg.link_up};

    `SBAR_ASSERT_NEXT(a_cfg_reload, cfg_wr,
        state_reg.mode_basex == cfg.basex && state_reg.supported == cfg.supported &&
        state_reg.advertised == cfg.advertised && state_reg.last_speed == SPD_10M,
        "state not reloaded from configuration")
    `SBAR_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance, in_valid_reg,
        "input stage dropped an item")
    `SBAR_ASSERT_NOW(a_link_down, out_valid_reg && res_reg.outcome == OUTC_LINK_DOWN,
        !res_reg.link_up && !res_reg.speed_write && !res_reg.mode_switched,
        "link down result with side effects")
    `SBAR_ASSERT_NEXT(a_state_quiet, !advance && !cfg_wr, $stable(state_reg),
        "held state changed without an item")

endmodule
